### rtl/silence_run_remover_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the silence run remover core
// Shared property forms; each expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef SILENCE_RUN_REMOVER_CORE_MACROS_SVH
`define SILENCE_RUN_REMOVER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srr: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srr: next-cycle check failed");

`endif

### rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared constants, types and codes for the silence run remover.
// ----------------------------------------------------------------------------
package srr_pkg;

    // Run limits and held-sample store geometry
    localparam int MAX_RUN    = 64;
    localparam int HELD_DEPTH = MAX_RUN - 1;
    localparam int HELD_AW    = $clog2(HELD_DEPTH);
    localparam int CNT_W      = $clog2(MAX_RUN + 1);

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 15;
    localparam int MINLEN_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_SILENCE_LEVEL      = 2'd0;
    localparam cfg_index_t CFG_MIN_SILENCE_LENGTH = 2'd1;

    // Register reset values
    localparam logic [LEVEL_W-1:0]  LEVEL_RST  = '0;
    localparam logic [MINLEN_W-1:0] MINLEN_RST = 7'd8;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HELD,
        ST_TAIL
    } srr_state_t;

    // Write port of the held-sample store
    typedef struct packed {
        logic                       en;
        logic [HELD_AW-1:0]         addr;
        logic signed [SAMPLE_W-1:0] data;
    } held_wr_t;

endpackage

### rtl/srr_held_mem.sv
// ----------------------------------------------------------------------------
// srr_held_mem
// Held-sample store: one write port, one registered read port, with a
// bypass so a read of the entry written at the same edge returns new data.
// ----------------------------------------------------------------------------
module srr_held_mem (
    input  logic                                        clk,
    input  srr_pkg::held_wr_t                           wr,
    input  logic [srr_pkg::HELD_AW-1:0]                 rd_addr,
    output logic signed [srr_pkg::SAMPLE_W-1:0]         rd_data
);
    import srr_pkg::*;

    logic signed [SAMPLE_W-1:0] held_mem [HELD_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_q_reg;
    logic signed [SAMPLE_W-1:0] byp_data_reg;
    logic                       byp_reg;

    // Write the array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            held_mem[wr.addr] <= wr.data;
        end
    end

    // Read the array, note a same-entry write for forwarding
    always_ff @(posedge clk)
    begin
        rd_q_reg     <= held_mem[rd_addr];
        byp_reg      <= wr.en && (wr.addr == rd_addr);
        byp_data_reg <= wr.data;
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

### rtl/silence_run_remover_core.sv
// ----------------------------------------------------------------------------
// silence_run_remover_core
// Drops silent runs that reach the minimum length; re-emits shorter runs.
// ----------------------------------------------------------------------------
// Flow: silent words are taken while the sequencer is idle; a run end with nothing
//   held waits in the tail state while the output reg is held; a flush emits the held
//   samples, then a loud word behind them, paced by the single read port of the store;
//   input stalls meanwhile. Flushed samples pass the store's read reg first.
// Reset: clears sequencer, run count and output valid; registers go to level 0
//   and minimum length 8. The sample store is not cleared.
`include "silence_run_remover_core_macros.svh"

module silence_run_remover_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [srr_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [srr_pkg::CFG_DATA_W-1:0]          cfg_data,
    // Input channel
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [srr_pkg::SAMPLE_W-1:0]     sample,
    input  logic                                    stream_last,
    // Output channel
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [srr_pkg::SAMPLE_W-1:0]     out_sample,
    output logic                                    has_sample,
    output logic                                    run_last,
    output logic                                    stream_end
);
    import srr_pkg::*;

    // Configuration registers
    logic [LEVEL_W-1:0]         level_reg;
    logic [MINLEN_W-1:0]        min_len_reg;

    // Sequencer and run state
    srr_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [HELD_AW-1:0]         idx_reg, idx_next;
    logic [HELD_AW-1:0]         held_cnt_reg, held_cnt_next;
    logic                       loud_reg, loud_next;
    logic                       last_reg, last_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                       has_sample_reg, has_sample_next;
    logic                       run_last_reg, run_last_next;
    logic                       stream_end_reg, stream_end_next;

    // Combinational helpers
    logic                       in_acc;
    logic                       slot_free;
    logic [SAMPLE_W:0]          mag;
    logic                       silent;
    logic                       ends;
    logic [CNT_W-1:0]           count_inc;
    logic [CNT_W-1:0]           count_new;
    logic [MINLEN_W-1:0]        eff_min;
    logic                       emit_held;
    logic [HELD_AW-1:0]         held_n;
    logic                       last_held;
    held_wr_t                   held_wr;
    logic signed [SAMPLE_W-1:0] held_rd;

    // Configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= LEVEL_RST;
            min_len_reg <= MINLEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SILENCE_LEVEL:      level_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_MIN_SILENCE_LENGTH: min_len_reg <= cfg_data[MINLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the incoming word and work out the run decision
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        mag       = sample[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({sample[SAMPLE_W-1], sample}))
                                       : (SAMPLE_W+1)'({1'b0, sample});
        silent    = (mag <= (SAMPLE_W+1)'(level_reg));
        ends      = !silent || stream_last;
        count_inc = (count_reg < CNT_W'(MAX_RUN)) ? count_reg + CNT_W'(1) : count_reg;
        count_new = silent ? count_inc : count_reg;
        if (min_len_reg == '0)
        begin
            eff_min = MINLEN_W'(1);
        end
        else if (min_len_reg > MINLEN_W'(MAX_RUN))
        begin
            eff_min = MINLEN_W'(MAX_RUN);
        end
        else
        begin
            eff_min = min_len_reg;
        end
        emit_held = (count_new != '0) && (CNT_W'(count_new) < CNT_W'(eff_min));
        held_n    = emit_held ? count_new[HELD_AW-1:0] : '0;
        last_held = (idx_reg == held_cnt_reg - HELD_AW'(1));
    end

    // Store silent samples of the current run
    always_comb
    begin
        held_wr.en   = in_acc && silent && (count_reg < CNT_W'(HELD_DEPTH));
        held_wr.addr = count_reg[HELD_AW-1:0];
        held_wr.data = sample;
    end

    srr_held_mem u_held_mem (
        .clk     (clk),
        .wr      (held_wr),
        .rd_addr (idx_next),
        .rd_data (held_rd)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && ends)
                begin
                    if (held_n != '0)
                    begin
                        state_next = ST_HELD;
                    end
                    else if (!slot_free)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_HELD:
            begin
                if (slot_free && last_held)
                begin
                    state_next = loud_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register loads
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        held_cnt_next   = held_cnt_reg;
        loud_next       = loud_reg;
        last_next       = last_reg;
        smp_next        = smp_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        has_sample_next = has_sample_reg;
        run_last_next   = run_last_reg;
        stream_end_next = stream_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    count_next = ends ? '0 : count_new;
                    if (ends)
                    begin
                        // Capture the word that closes the run
                        idx_next      = '0;
                        held_cnt_next = held_n;
                        loud_next     = !silent;
                        last_next     = stream_last;
                        smp_next      = sample;
                        if (held_n == '0 && slot_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_sample_next = silent ? '0 : sample;
                            has_sample_next = !silent;
                            run_last_next   = 1'b1;
                            stream_end_next = stream_last;
                        end
                    end
                end
            end
            ST_HELD:
            begin
                if (slot_free)
                begin
                    // Emit one held sample and advance the read pointer
                    out_valid_next  = 1'b1;
                    out_sample_next = held_rd;
                    has_sample_next = 1'b1;
                    run_last_next   = last_held && !loud_reg;
                    stream_end_next = last_held && !loud_reg && last_reg;
                    idx_next        = idx_reg + HELD_AW'(1);
                end
            end
            ST_TAIL:
            begin
                if (slot_free)
                begin
                    // Emit the loud word or the stream end marker
                    out_valid_next  = 1'b1;
                    out_sample_next = loud_reg ? smp_reg : '0;
                    has_sample_next = loud_reg;
                    run_last_next   = 1'b1;
                    stream_end_next = last_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        held_cnt_reg   <= held_cnt_next;
        loud_reg       <= loud_next;
        last_reg       <= last_next;
        smp_reg        <= smp_next;
        out_sample_reg <= out_sample_next;
        has_sample_reg <= has_sample_next;
        run_last_reg   <= run_last_next;
        stream_end_reg <= stream_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign has_sample = has_sample_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;

    // Checks
    `SRR_ASSERT_NOW(a_held_idx_in_range, state_reg == ST_HELD, idx_reg < held_cnt_reg)
    `SRR_ASSERT_NEXT(a_run_closed_clears_count, in_acc && ends, count_reg == '0)
    `SRR_ASSERT_NOW(a_stream_end_is_run_last, out_valid && stream_end, run_last)

endmodule
